/* hw/rtl/kts_pkg.sv */
// Shared types, token codes and character helpers for the keyword token scanner.
package kts_pkg;

	// Scanner mode between input transactions
	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_IDENT  = 2'd1,
		MODE_STRING = 2'd2
	} mode_t;

	// Record types
	localparam logic REC_TEXT = 1'b0;
	localparam logic REC_DONE = 1'b1;

	// Token kinds
	localparam logic [3:0] KIND_IDENT   = 4'd0;
	localparam logic [3:0] KIND_DEF     = 4'd1;
	localparam logic [3:0] KIND_ECHO    = 4'd2;
	localparam logic [3:0] KIND_RETURN  = 4'd3;
	localparam logic [3:0] KIND_NUMBER  = 4'd4;
	localparam logic [3:0] KIND_STRING  = 4'd5;
	localparam logic [3:0] KIND_LPAREN  = 4'd6;
	localparam logic [3:0] KIND_RPAREN  = 4'd7;
	localparam logic [3:0] KIND_LBRACE  = 4'd8;
	localparam logic [3:0] KIND_RBRACE  = 4'd9;
	localparam logic [3:0] KIND_SEMI    = 4'd10;
	localparam logic [3:0] KIND_UNKNOWN = 4'd11;
	localparam logic [3:0] KIND_EOF     = 4'd12;

	// Keywords, left aligned in six bytes, with their lengths
	localparam int NUM_KW = 3;
	localparam logic [47:0] KW_STR [NUM_KW] = '{
		48'h646566_000000,   // def
		48'h6563686F_0000,   // echo
		48'h72657475726E     // return
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd4, 3'd6};

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// One output record and a bundle of up to three per transaction
	localparam int MAX_RECS = 3;

	typedef struct packed {
		logic       rec_type;
		logic [3:0] kind;
		logic [7:0] text;
	} rec_t;

	typedef struct packed {
		logic [1:0]               count;
		rec_t [MAX_RECS-1:0]      recs;
	} bundle_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// Keywords that still match after adding byte c at position pos
	function automatic logic [2:0] kw_step(input logic [2:0] pos, input logic [7:0] c);
		logic [2:0] hit;
		hit = 3'b000;
		for (int k = 0; k < NUM_KW; k++) begin
			if (pos < KW_LEN[k] && pos < 3'd6) begin
				hit[k] = (KW_STR[k][8*(5-int'(pos)) +: 8] == c);
			end
		end
		return hit;
	endfunction

	// Kind of a finished identifier; lowest keyword wins
	function automatic logic [3:0] ident_kind(input logic [2:0] alive, input logic [2:0] len);
		logic [3:0] kind;
		kind = KIND_IDENT;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (alive[k] && len == KW_LEN[k]) begin
				kind = 4'(k + 1);
			end
		end
		return kind;
	endfunction

	// Kind of a one-byte token seen while idle
	function automatic logic [3:0] sym_kind(input logic [7:0] c);
		logic [3:0] kind;
		if (is_digit(c))        kind = KIND_NUMBER;
		else if (c == 8'h28)    kind = KIND_LPAREN;
		else if (c == 8'h29)    kind = KIND_RPAREN;
		else if (c == 8'h7B)    kind = KIND_LBRACE;
		else if (c == 8'h7D)    kind = KIND_RBRACE;
		else if (c == 8'h3B)    kind = KIND_SEMI;
		else                    kind = KIND_UNKNOWN;
		return kind;
	endfunction

endpackage

/* hw/rtl/kts_front.sv */
// Front end: classifies each source byte, tracks scan state and builds a record bundle.
module kts_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       char_in,
	input  logic             end_only,
	output logic             q_push,
	output kts_pkg::bundle_t q_data
);
	import kts_pkg::*;

	mode_t      mode_q, mode_d;
	logic [2:0] alive_q, alive_d;
	logic [2:0] len_q, len_d;
	bundle_t    bnd;
	logic [1:0] n;
	logic       do_idle;

	// Scan state registers, updated once per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			alive_q <= 3'b000;
			len_q   <= 3'd0;
		end else if (accept) begin
			mode_q  <= mode_d;
			alive_q <= alive_d;
			len_q   <= len_d;
		end
	end

	// Next state and record bundle for the current byte
	always_comb begin
		mode_d  = mode_q;
		alive_d = alive_q;
		len_d   = len_q;
		bnd     = '0;
		n       = 2'd0;
		do_idle = 1'b0;

		if (end_only) begin
			if (mode_q == MODE_IDENT) begin
				bnd.recs[n] = '{REC_DONE, ident_kind(alive_q, len_q), 8'h00};
				n = n + 2'd1;
			end else if (mode_q == MODE_STRING) begin
				bnd.recs[n] = '{REC_DONE, KIND_STRING, 8'h00};
				n = n + 2'd1;
			end
			bnd.recs[n] = '{REC_DONE, KIND_EOF, 8'h00};
			n = n + 2'd1;
			mode_d  = MODE_IDLE;
			alive_d = 3'b000;
			len_d   = 3'd0;
		end else begin
			case (mode_q)
				MODE_IDENT: begin
					if (is_alpha(char_in) || is_digit(char_in) || char_in == 8'h5F) begin
						alive_d = alive_q & kw_step(len_q, char_in);
						len_d   = (len_q == 3'd7) ? len_q : len_q + 3'd1;
						bnd.recs[n] = '{REC_TEXT, KIND_IDENT, char_in};
						n = n + 2'd1;
					end else begin
						bnd.recs[n] = '{REC_DONE, ident_kind(alive_q, len_q), 8'h00};
						n = n + 2'd1;
						mode_d  = MODE_IDLE;
						alive_d = 3'b000;
						len_d   = 3'd0;
						do_idle = 1'b1;
					end
				end
				MODE_STRING: begin
					if (char_in == 8'h22 || char_in == 8'h00) begin
						bnd.recs[n] = '{REC_DONE, KIND_STRING, 8'h00};
						n = n + 2'd1;
						mode_d = MODE_IDLE;
					end else begin
						bnd.recs[n] = '{REC_TEXT, KIND_IDENT, char_in};
						n = n + 2'd1;
					end
				end
				default: begin
					mode_d  = MODE_IDLE;
					do_idle = 1'b1;
				end
			endcase

			// Byte seen between tokens
			if (do_idle) begin
				if (is_space(char_in)) begin
					// skipped
				end else if (is_alpha(char_in)) begin
					mode_d  = MODE_IDENT;
					alive_d = kw_step(3'd0, char_in);
					len_d   = 3'd1;
					bnd.recs[n] = '{REC_TEXT, KIND_IDENT, char_in};
					n = n + 2'd1;
				end else if (char_in == 8'h22) begin
					mode_d = MODE_STRING;
				end else begin
					bnd.recs[n] = '{REC_TEXT, KIND_IDENT, char_in};
					n = n + 2'd1;
					bnd.recs[n] = '{REC_DONE, sym_kind(char_in), 8'h00};
					n = n + 2'd1;
				end
			end
		end
		bnd.count = n;
	end

	assign q_push = accept && (n != 2'd0);
	assign q_data = bnd;

endmodule

/* hw/rtl/kts_fifo.sv */
// Small register queue of record bundles between front and back ends.
module kts_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* hw/rtl/kts_back.sv */
// Back end: unpacks bundles and presents one record per transaction on the result side.
module kts_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  kts_pkg::bundle_t q_data,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output logic             record_type,
	output logic [3:0]       token_kind,
	output logic [7:0]       text_byte,
	output logic             run_last
);
	import kts_pkg::*;

	bundle_t    bundle_q;
	logic [1:0] idx_q;
	logic       valid_q;
	logic       last;
	logic       load;
	rec_t       cur;

	assign last  = (idx_q == bundle_q.count - 2'd1);
	assign load  = !valid_q || (pop && last);
	assign q_pop = load && !q_empty;
	assign empty = !valid_q;

	// Current bundle and record index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= !q_empty;
			idx_q   <= 2'd0;
		end else if (pop) begin
			idx_q   <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			bundle_q <= q_data;
		end
	end

	// Record selection
	always_comb begin
		case (idx_q)
			2'd0:    cur = bundle_q.recs[0];
			2'd1:    cur = bundle_q.recs[1];
			2'd2:    cur = bundle_q.recs[2];
			default: cur = '0;
		endcase
	end

	assign record_type = cur.rec_type;
	assign token_kind  = cur.kind;
	assign text_byte   = cur.text;
	assign run_last    = last;

endmodule

/* hw/rtl/keyword_token_scanner_top.sv */
// Top level of the keyword token scanner: front end, bundle queue and back end.
// Path: an accepted byte's bundle is written into the queue, then loaded into the back end's
// bundle register before its first record appears. Throughput: one byte accepted per cycle
// while the bundle queue has room; records leave at one per cycle while the reader pops.
// Reset: arst_n clears scan mode, keyword and length state, queue pointers and result valid.
module keyword_token_scanner_top #(
	parameter int QUEUE_DEPTH = kts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_in,
	input  logic       end_only,
	output logic       empty,
	input  logic       pop,
	output logic       record_type,
	output logic [3:0] token_kind,
	output logic [7:0] text_byte,
	output logic       run_last
);
	import kts_pkg::*;

	logic    accept;
	logic    q_push, q_pop, q_full, q_empty;
	bundle_t q_wdata, q_rdata;

	assign full   = q_full;
	assign accept = push && !q_full;

	// Classification
	kts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.char_in  (char_in),
		.end_only (end_only),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	// Bundle queue
	kts_fifo #(
		.WIDTH ($bits(bundle_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	// Record output
	kts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.record_type (record_type),
		.token_kind  (token_kind),
		.text_byte   (text_byte),
		.run_last    (run_last)
	);

	// Checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("bundle pushed into full queue");

	a_text_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && record_type == REC_TEXT) |-> token_kind == KIND_IDENT)
		else $error("text record carries a token kind");

	a_done_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && record_type == REC_DONE) |-> text_byte == 8'h00)
		else $error("complete record carries a text byte");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && record_type == REC_DONE && token_kind == KIND_EOF) |-> run_last)
		else $error("end-of-file record is not last of its transaction");

endmodule

/* dv/keyword_token_scanner_top_tb.sv */
// Self-checking testbench for the keyword token scanner top level.
`timescale 1ns / 100ps

module keyword_token_scanner_top_tb;
	import kts_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_ITEMS = 500;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_NUL = 8'h00;

	// One expected record, as it should leave the block
	typedef struct packed {
		logic       rec_type;
		logic [3:0] kind;
		logic [7:0] text;
		logic       last;
	} exp_rec_t;

	// One row of the directed table; typed rows carry their records
	typedef struct packed {
		logic [7:0]         c;
		logic               e;
		logic               typed;
		logic [1:0]         n;
		exp_rec_t [1:0]     recs;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] char_in;
	logic       end_only;
	logic       empty;
	logic       pop;
	logic       record_type;
	logic [3:0] token_kind;
	logic [7:0] text_byte;
	logic       run_last;

	keyword_token_scanner_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.char_in    (char_in),
		.end_only   (end_only),
		.empty      (empty),
		.pop        (pop),
		.record_type(record_type),
		.token_kind (token_kind),
		.text_byte  (text_byte),
		.run_last   (run_last)
	);

	// Clock, 4 ns period
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Keyword spellings and the kinds they report
	logic [7:0] kw_chars [3][6] = '{
		'{"d", "e", "f", 8'h00, 8'h00, 8'h00},
		'{"e", "c", "h", "o", 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n"}
	};
	logic [2:0] kw_size [3] = '{3'd3, 3'd4, 3'd6};
	logic [3:0] kw_kind [3] = '{KIND_DEF, KIND_ECHO, KIND_RETURN};

	// Scanner state held by the predictor
	mode_t      lex_mode;
	logic [2:0] kw_live;
	logic [2:0] name_len;
	exp_rec_t   step_recs[$];

	// Records still owed by the block, oldest first
	exp_rec_t   records_due[$];

	int          errors;
	int unsigned sent_items;
	int unsigned cycles;
	bit          tx_steady;
	bit          rx_steady;

	function automatic bit letter_byte(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit digit_byte(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit blank_byte(logic [7:0] c);
		return c == " " || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic void emit(logic t, logic [3:0] k, logic [7:0] b);
		exp_rec_t r;
		r.rec_type = t;
		r.kind = k;
		r.text = b;
		r.last = 1'b0;
		step_recs = {step_recs, r};
	endfunction

	function automatic void scanner_clear();
		lex_mode = MODE_IDLE;
		kw_live = 3'b000;
		name_len = 3'd0;
	endfunction

	// Drop keywords that no longer match; length saturates at seven
	function automatic void name_extend(logic [7:0] c);
		for (int k = 0; k < 3; k++) begin
			if (name_len >= kw_size[k] || kw_chars[k][name_len] != c)
				kw_live[k] = 1'b0;
		end
		if (name_len < 3'd7)
			name_len = name_len + 3'd1;
	endfunction

	function automatic logic [3:0] name_kind();
		for (int k = 0; k < 3; k++) begin
			if (kw_live[k] && name_len == kw_size[k])
				return kw_kind[k];
		end
		return KIND_IDENT;
	endfunction

	// A byte seen between tokens
	function automatic void idle_char(logic [7:0] c);
		logic [3:0] k;
		if (blank_byte(c))
			return;
		if (letter_byte(c)) begin
			lex_mode = MODE_IDENT;
			kw_live = 3'b111;
			name_len = 3'd0;
			name_extend(c);
			emit(REC_TEXT, '0, c);
			return;
		end
		if (c == CH_QUOTE) begin
			lex_mode = MODE_STRING;
			return;
		end
		if (digit_byte(c))   k = KIND_NUMBER;
		else if (c == "(")   k = KIND_LPAREN;
		else if (c == ")")   k = KIND_RPAREN;
		else if (c == "{")   k = KIND_LBRACE;
		else if (c == "}")   k = KIND_RBRACE;
		else if (c == ";")   k = KIND_SEMI;
		else                 k = KIND_UNKNOWN;
		emit(REC_TEXT, '0, c);
		emit(REC_DONE, k, 8'h00);
	endfunction

	// Records caused by one accepted transaction, left in step_recs
	function automatic void lex_step(logic [7:0] c, logic e);
		step_recs.delete();
		if (e) begin
			if (lex_mode == MODE_IDENT)
				emit(REC_DONE, name_kind(), 8'h00);
			else if (lex_mode == MODE_STRING)
				emit(REC_DONE, KIND_STRING, 8'h00);
			emit(REC_DONE, KIND_EOF, 8'h00);
			scanner_clear();
		end else begin
			case (lex_mode)
				MODE_IDENT: begin
					if (letter_byte(c) || digit_byte(c) || c == CH_UNDERSCORE) begin
						name_extend(c);
						emit(REC_TEXT, '0, c);
					end else begin
						emit(REC_DONE, name_kind(), 8'h00);
						scanner_clear();
						idle_char(c);
					end
				end
				MODE_STRING: begin
					if (c == CH_QUOTE || c == CH_NUL) begin
						emit(REC_DONE, KIND_STRING, 8'h00);
						lex_mode = MODE_IDLE;
					end else begin
						emit(REC_TEXT, '0, c);
					end
				end
				default: begin
					lex_mode = MODE_IDLE;
					idle_char(c);
				end
			endcase
		end
		if (step_recs.size() > 0)
			step_recs[step_recs.size() - 1].last = 1'b1;
	endfunction

	function automatic int draw_wait(bit steady);
		return steady ? 0 : int'($urandom_range(0, 13));
	endfunction

	// Offer one transaction after a random gap and wait until it is taken
	task automatic send_char(input logic [7:0] c, input logic e);
		int gap;
		gap = draw_wait(tx_steady);
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		char_in <= c;
		end_only <= e;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic feed(input logic [7:0] c, input logic e);
		send_char(c, e);
		lex_step(c, e);
		sent_items++;
		records_due = {records_due, step_recs};
	endtask

	// Hold the sender off until every owed record has come out
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (records_due.size() != 0) @(posedge clk);
	endtask

	function automatic exp_rec_t txt(logic [7:0] b, logic last);
		return '{REC_TEXT, 4'd0, b, last};
	endfunction

	function automatic exp_rec_t done(logic [3:0] k, logic last);
		return '{REC_DONE, k, 8'h00, last};
	endfunction

	function automatic stim_row_t chk(logic [7:0] c, logic e, logic [1:0] n,
			exp_rec_t r0, exp_rec_t r1);
		stim_row_t row;
		row.c = c;
		row.e = e;
		row.typed = 1'b1;
		row.n = n;
		row.recs[0] = r0;
		row.recs[1] = r1;
		return row;
	endfunction

	function automatic stim_row_t pred(logic [7:0] c, logic e);
		stim_row_t row;
		row = '0;
		row.c = c;
		row.e = e;
		return row;
	endfunction

	function automatic logic [7:0] word_byte();
		int r;
		r = $urandom_range(0, 62);
		if (r < 26)      return 8'("a" + r);
		else if (r < 52) return 8'("A" + r - 26);
		else if (r < 62) return 8'("0" + r - 52);
		return CH_UNDERSCORE;
	endfunction

	// One token, mostly well formed, followed by optional whitespace
	task automatic random_token();
		int pick;
		int len;
		int kw;
		int variant;
		int flip;
		logic [7:0] b;
		pick = $urandom_range(0, 19);
		if (pick < 5) begin
			// keyword, exact or nearly so
			kw = $urandom_range(0, 2);
			variant = $urandom_range(0, 5);
			len = kw_size[kw] - ((variant == 3) ? 1 : 0);
			flip = $urandom_range(0, len - 1);
			for (int i = 0; i < len; i++) begin
				b = kw_chars[kw][i];
				if (variant == 5 && i == flip)
					b = b - 8'h20;
				feed(b, 1'b0);
			end
			if (variant == 4)
				feed(word_byte(), 1'b0);
		end else if (pick < 8) begin
			// plain identifier, some past the saturating length
			len = $urandom_range(1, 10);
			b = 8'($urandom_range(0, 51));
			feed((b < 26) ? 8'("a" + b) : 8'("A" + b - 26), 1'b0);
			for (int i = 1; i < len; i++)
				feed(word_byte(), 1'b0);
		end else if (pick < 11) begin
			// quoted text, closed by a quote, a NUL, or left open
			feed(CH_QUOTE, 1'b0);
			len = $urandom_range(0, 6);
			for (int i = 0; i < len; i++) begin
				do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
				feed(b, 1'b0);
			end
			variant = $urandom_range(0, 7);
			if (variant < 6)
				feed(CH_QUOTE, 1'b0);
			else if (variant == 6)
				feed(CH_NUL, 1'b0);
		end else if (pick < 13) begin
			feed(8'("0" + $urandom_range(0, 9)), 1'b0);
		end else if (pick < 16) begin
			case ($urandom_range(0, 4))
				0: feed("(", 1'b0);
				1: feed(")", 1'b0);
				2: feed("{", 1'b0);
				3: feed("}", 1'b0);
				default: feed(";", 1'b0);
			endcase
		end else if (pick < 18) begin
			feed(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			feed(8'($urandom_range(0, 255)), 1'b1);
		end
		len = $urandom_range(0, 3);
		if (len == 3)
			len = $urandom_range(2, 3);
		else if (len == 2)
			len = 1;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 5));
			feed((b == 0) ? 8'h20 : 8'(8'h08 + b), 1'b0);
		end
	endtask

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: random stalls, then compare against the oldest owed record
	initial begin
		int stall;
		exp_rec_t want;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(rx_steady);
			@(negedge clk);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			if (records_due.size() == 0) begin
				$error("unexpected record: type %0d kind %0d byte 0x%02h last %0d",
					record_type, token_kind, text_byte, run_last);
				errors++;
			end else begin
				want = records_due.pop_front();
				if (record_type !== want.rec_type) begin
					$error("record_type: expected %0d, got %0d", want.rec_type, record_type);
					errors++;
				end
				if (token_kind !== want.kind) begin
					$error("token_kind: expected %0d, got %0d", want.kind, token_kind);
					errors++;
				end
				if (text_byte !== want.text) begin
					$error("text_byte: expected 0x%02h, got 0x%02h", want.text, text_byte);
					errors++;
				end
				if (run_last !== want.last) begin
					$error("run_last: expected %0d, got %0d", want.last, run_last);
					errors++;
				end
			end
		end
	end

	// Stimulus: reset, directed table, random tokens, final drain
	initial begin
		stim_row_t dir_rows[$];
		int rounds;
		bit paused;
		push = 1'b0;
		pop = 1'b0;
		char_in = 8'h00;
		end_only = 1'b0;
		arst_n = 1'b0;
		errors = 0;
		cycles = 0;
		sent_items = 0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		scanner_clear();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		dir_rows = '{
			chk(8'h00, 1'b1, 2'd1, done(KIND_EOF, 1'b1), '0),
			chk(" ", 1'b0, 2'd0, '0, '0),
			chk(8'h09, 1'b0, 2'd0, '0, '0),
			chk(8'h00, 1'b0, 2'd2, txt(8'h00, 1'b0), done(KIND_UNKNOWN, 1'b1)),
			chk(8'hFF, 1'b0, 2'd2, txt(8'hFF, 1'b0), done(KIND_UNKNOWN, 1'b1)),
			chk("(", 1'b0, 2'd2, txt("(", 1'b0), done(KIND_LPAREN, 1'b1)),
			chk(")", 1'b0, 2'd2, txt(")", 1'b0), done(KIND_RPAREN, 1'b1)),
			chk("{", 1'b0, 2'd2, txt("{", 1'b0), done(KIND_LBRACE, 1'b1)),
			chk("0", 1'b0, 2'd2, txt("0", 1'b0), done(KIND_NUMBER, 1'b1)),
			chk("9", 1'b0, 2'd2, txt("9", 1'b0), done(KIND_NUMBER, 1'b1)),
			// def closed by a semicolon: three records from one byte
			pred("d", 1'b0), pred("e", 1'b0), pred("f", 1'b0), pred(";", 1'b0),
			// empty quoted text
			pred(CH_QUOTE, 1'b0), pred(CH_QUOTE, 1'b0),
			// quoted text ended by NUL
			pred(CH_QUOTE, 1'b0), pred("a", 1'b0), pred(CH_NUL, 1'b0),
			// identifier closed by a brace
			pred("E", 1'b0), pred("7", 1'b0), pred("}", 1'b0),
			// open quoted text closed by end of source
			pred(CH_QUOTE, 1'b0), pred(8'hFF, 1'b0), pred(8'h80, 1'b1)
		};

		foreach (dir_rows[i]) begin
			send_char(dir_rows[i].c, dir_rows[i].e);
			lex_step(dir_rows[i].c, dir_rows[i].e);
			if (dir_rows[i].typed) begin
				for (int j = 0; j < dir_rows[i].n; j++)
					records_due = {records_due, dir_rows[i].recs[j]};
			end else begin
				records_due = {records_due, step_recs};
			end
		end
		drain();

		sent_items = 0;
		rounds = 0;
		paused = 1'b0;
		while (sent_items < RANDOM_ITEMS) begin
			// change who idles every so often, including runs with no idling
			if (rounds % 40 == 0)
				{tx_steady, rx_steady} = 2'($urandom_range(0, 3));
			if (!paused && sent_items >= RANDOM_ITEMS / 2) begin
				drain();
				paused = 1'b1;
			end
			random_token();
			rounds++;
		end

		drain();
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
